@@ design/lbem_pkg.sv @@
// Shared types and constants for the load-based energy meter.
package lbem_pkg;

    // Default size of the pstate power table.
    localparam int LBEM_NUM_PSTATES = 8;

    // Field widths.
    localparam int TIME_W   = 48;
    localparam int PWR_W    = 32;
    localparam int CORE_W   = 9;
    localparam int PS_W     = 3;
    localparam int ACC_W    = 63;
    localparam int FRAC_W   = 17;
    localparam int DIV_W    = PWR_W + CORE_W;
    localparam int SLOPE_W  = PWR_W + FRAC_W;
    localparam int EPROD_W  = PWR_W + TIME_W;
    localparam int CNT_W    = 6;

    // Iteration counts of the serial units.
    localparam int DIV_STEPS   = FRAC_W - 1;
    localparam int SLOPE_STEPS = FRAC_W;
    localparam int TIME_STEPS  = TIME_W;

    // Load fraction of 1.0 in Q1.16.
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);
    // Largest accumulator value.
    localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};

    // Input item kinds carried on tuser.
    localparam logic CMD_UPDATE   = 1'b0;
    localparam logic CMD_TABLE_WR = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_OFF_POWER  = 1'b0;
    localparam logic CFG_CORE_COUNT = 1'b1;

    // One pstate table entry as stored in memory.
    typedef struct packed {
        logic [PWR_W-1:0] speed;
        logic [PWR_W-1:0] max_pwr;
        logic [PWR_W-1:0] eps_pwr;
        logic [PWR_W-1:0] idle_pwr;
    } entry_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SETUP,
        ST_CMP,
        ST_DIV,
        ST_SLOPE,
        ST_POWER,
        ST_ENERGY,
        ST_FINISH
    } state_t;

endpackage

@@ design/lbem_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module lbem_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ design/load_based_energy_meter.sv @@
// Top level of the load-based energy meter: sequencer, serial datapath and table.
//
// A table-write item is written from the idle state, which stays ready for the next item.
// The result of an update event is posted after a path of states set by the latched state.
// The longest path runs the 16-step restoring divider for the load fraction, which follows
// a table read, a 32x9 divisor multiply and a compare. A load that reaches the divisor
// clamps the fraction to one and skips the divider, and a zero speed also skips the
// multiply and the compare. The off power or an idle entry skips the slope as well, and a
// time that is not later than the last update goes straight to the result. The loaded
// paths run a 17-step shift-add slope multiply. Every charged interval runs a 48-step
// bit-serial multiply of power by elapsed ticks, which dominates the path. The next item
// is accepted at the earliest in the cycle after a result is posted. A finished result
// sits in an output register, so the next item may be accepted while it waits. The
// following update event then holds in its last step until that register empties. The
// pstate table resets to all zero through per-entry valid bits; no clearing pass.
module load_based_energy_meter
    import lbem_pkg::*;
#(
    parameter int NUM_PSTATES = LBEM_NUM_PSTATES
) (
    input  logic         clk,
    input  logic         rst_n,
    // Input items.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // now_time[47:0], host_on[48], new_pstate[51:49], load_rate[83:52],
    // table_index[86:84], idle_pwr[118:87], eps_pwr[150:119],
    // max_pwr[182:151], pstate_speed[214:183], zero[215]
    input  logic [215:0] s_axis_tdata,
    // cmd[0]
    input  logic         s_axis_tuser,
    // Result items.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // energy_total[62:0], interval_power[94:63], host_used[95],
    // energy_saturated[96], zero[103:97]
    output logic [103:0] m_axis_tdata,
    // Configuration writes.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_addr,
    input  logic [31:0]  cfg_data
);

    localparam int AW = (NUM_PSTATES > 1) ? $clog2(NUM_PSTATES) : 1;

    // Input field views.
    logic [TIME_W-1:0] in_now;
    logic              in_host_on;
    logic [PS_W-1:0]   in_new_pstate;
    logic [PWR_W-1:0]  in_load;
    logic [PS_W-1:0]   in_table_index;
    entry_t            in_entry;

    assign in_now           = s_axis_tdata[47:0];
    assign in_host_on       = s_axis_tdata[48];
    assign in_new_pstate    = s_axis_tdata[51:49];
    assign in_load          = s_axis_tdata[83:52];
    assign in_table_index   = s_axis_tdata[86:84];
    assign in_entry.idle_pwr = s_axis_tdata[118:87];
    assign in_entry.eps_pwr  = s_axis_tdata[150:119];
    assign in_entry.max_pwr  = s_axis_tdata[182:151];
    assign in_entry.speed    = s_axis_tdata[214:183];

    // Control state.
    state_t                   state_reg, state_next;
    logic [NUM_PSTATES-1:0]   valid_reg, valid_next;
    logic                     m_valid_reg, m_valid_next;
    logic [PS_W-1:0]          latched_pstate_reg, latched_pstate_next;
    logic                     latched_off_reg, latched_off_next;
    logic [TIME_W-1:0]        last_time_reg, last_time_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic                     used_reg, used_next;
    logic [PWR_W-1:0]         off_power_reg, off_power_next;
    logic [CORE_W-1:0]        core_count_reg, core_count_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    // Datapath state.
    logic                     later_reg, later_next;
    logic                     host_on_reg, host_on_next;
    logic [PS_W-1:0]          new_pstate_reg, new_pstate_next;
    logic [PWR_W-1:0]         load_reg, load_next;
    logic [DIV_W-1:0]         div_reg, div_next;
    logic [DIV_W-1:0]         rem_reg, rem_next;
    logic [DIV_STEPS-1:0]     quo_reg, quo_next;
    logic [PWR_W-1:0]         eps_reg, eps_next;
    logic [PWR_W-1:0]         diff_reg, diff_next;
    logic                     neg_reg, neg_next;
    logic [SLOPE_W-1:0]       prod_reg, prod_next;
    logic [PWR_W-1:0]         power_reg, power_next;
    logic [EPROD_W-1:0]       eprod_reg, eprod_next;
    logic [ACC_W-1:0]         out_energy_reg, out_energy_next;
    logic [PWR_W-1:0]         out_power_reg, out_power_next;
    logic                     out_used_reg, out_used_next;
    logic                     out_sat_reg, out_sat_next;

    // Table memory.
    logic                     ram_wr_en;
    logic [AW-1:0]            ram_wr_addr;
    logic [AW-1:0]            ram_rd_addr;
    entry_t                   ram_rd_data;

    assign ram_wr_addr = AW'(in_table_index);
    assign ram_rd_addr = AW'(latched_pstate_reg);

    lbem_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_PSTATES),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (in_entry),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Entry of the latched pstate; unwritten or out-of-table entries read as zero.
    logic   wr_in_range;
    logic   rd_in_range;
    logic   entry_ok;
    entry_t entry;

    assign wr_in_range = 32'(in_table_index) < NUM_PSTATES;
    assign rd_in_range = 32'(latched_pstate_reg) < NUM_PSTATES;
    assign entry_ok    = rd_in_range && valid_reg[ram_rd_addr];
    assign entry       = entry_ok ? ram_rd_data : '0;

    // Configuration port always takes writes.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        off_power_next  = off_power_reg;
        core_count_next = core_count_reg;
        if (cfg_valid)
        begin
            unique case (cfg_addr)
                CFG_OFF_POWER:  off_power_next  = cfg_data;
                CFG_CORE_COUNT: core_count_next = cfg_data[CORE_W-1:0];
                default:        off_power_next  = off_power_reg;
            endcase
        end
    end

    // Arithmetic helpers for the serial units.
    logic [CORE_W-1:0]  cores_eff;
    logic [DIV_W:0]     rem_shift;
    logic               quo_bit;
    logic [PWR_W:0]     slope_sum;
    logic [PWR_W:0]     slope_hi;
    logic [PWR_W:0]     slope_ceil;
    logic [PWR_W:0]     power_calc;
    logic [PWR_W:0]     energy_sum;
    logic [ACC_W:0]     acc_sum;
    logic [ACC_W-1:0]   acc_new;
    logic [TIME_W-1:0]  in_dt;

    assign cores_eff  = (core_count_reg == '0) ? CORE_W'(1) : core_count_reg;
    assign rem_shift  = {rem_reg, 1'b0};
    assign quo_bit    = rem_shift >= {1'b0, div_reg};
    assign slope_sum  = {1'b0, prod_reg[SLOPE_W-1:FRAC_W]}
                      + (prod_reg[0] ? {1'b0, diff_reg} : '0);
    assign slope_hi   = prod_reg[SLOPE_W-1:FRAC_W-1];
    assign slope_ceil = slope_hi + {{PWR_W{1'b0}}, |prod_reg[FRAC_W-2:0]};
    assign power_calc = neg_reg ? ({1'b0, eps_reg} - slope_ceil)
                                : ({1'b0, eps_reg} + slope_hi);
    assign energy_sum = {1'b0, eprod_reg[EPROD_W-1:TIME_W]}
                      + (eprod_reg[0] ? {1'b0, power_reg} : '0);
    assign acc_sum    = {1'b0, acc_reg} + {1'b0, eprod_reg[ACC_W-1:0]};
    assign in_dt      = in_now - last_time_reg;

    // Saturating accumulate of the finished energy product.
    always_comb
    begin
        if (!later_reg)
        begin
            acc_new = acc_reg;
        end
        else if ((|eprod_reg[EPROD_W-1:ACC_W]) || acc_sum[ACC_W])
        begin
            acc_new = ACC_MAX;
        end
        else
        begin
            acc_new = acc_sum[ACC_W-1:0];
        end
    end

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next          = state_reg;
        valid_next          = valid_reg;
        latched_pstate_next = latched_pstate_reg;
        latched_off_next    = latched_off_reg;
        last_time_next      = last_time_reg;
        acc_next            = acc_reg;
        used_next           = used_reg;
        cnt_next            = cnt_reg;
        later_next          = later_reg;
        host_on_next        = host_on_reg;
        new_pstate_next     = new_pstate_reg;
        load_next           = load_reg;
        div_next            = div_reg;
        rem_next            = rem_reg;
        quo_next            = quo_reg;
        eps_next            = eps_reg;
        diff_next           = diff_reg;
        neg_next            = neg_reg;
        prod_next           = prod_reg;
        power_next          = power_reg;
        eprod_next          = eprod_reg;
        out_energy_next     = out_energy_reg;
        out_power_next      = out_power_reg;
        out_used_next       = out_used_reg;
        out_sat_next        = out_sat_reg;
        s_axis_tready       = 1'b0;
        ram_wr_en           = 1'b0;

        // The result register empties when its transaction completes.
        m_valid_next = m_valid_reg && !m_axis_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == CMD_TABLE_WR)
                    begin
                        if (wr_in_range)
                        begin
                            ram_wr_en               = 1'b1;
                            valid_next[ram_wr_addr] = 1'b1;
                        end
                    end
                    else
                    begin
                        later_next      = in_now > last_time_reg;
                        host_on_next    = in_host_on;
                        new_pstate_next = in_new_pstate;
                        load_next       = in_load;
                        eprod_next      = {{PWR_W{1'b0}}, in_dt};
                        if (in_now > last_time_reg)
                        begin
                            last_time_next = in_now;
                        end
                        state_next = ST_READ;
                    end
                end
            end

            // Table read data settles for the latched pstate.
            ST_READ:
            begin
                state_next = ST_SETUP;
            end

            // Pick the power path of the latched state.
            ST_SETUP:
            begin
                cnt_next  = '0;
                eps_next  = entry.eps_pwr;
                neg_next  = entry.max_pwr < entry.eps_pwr;
                diff_next = (entry.max_pwr < entry.eps_pwr)
                          ? (entry.eps_pwr - entry.max_pwr)
                          : (entry.max_pwr - entry.eps_pwr);
                if (!later_reg)
                begin
                    power_next = '0;
                    state_next = ST_FINISH;
                end
                else if (latched_off_reg)
                begin
                    power_next = off_power_reg;
                    state_next = ST_ENERGY;
                end
                else if (entry.speed == '0)
                begin
                    prod_next  = {{PWR_W{1'b0}}, FRAC_ONE};
                    state_next = ST_SLOPE;
                end
                else if (load_reg == '0)
                begin
                    power_next = entry.idle_pwr;
                    state_next = ST_ENERGY;
                end
                else
                begin
                    used_next  = 1'b1;
                    div_next   = entry.speed * cores_eff;
                    state_next = ST_CMP;
                end
            end

            // A load at or above the divisor clamps the fraction to one.
            ST_CMP:
            begin
                if ({{CORE_W{1'b0}}, load_reg} >= div_reg)
                begin
                    prod_next  = {{PWR_W{1'b0}}, FRAC_ONE};
                    state_next = ST_SLOPE;
                end
                else
                begin
                    rem_next   = {{CORE_W{1'b0}}, load_reg};
                    quo_next   = '0;
                    state_next = ST_DIV;
                end
            end

            // Restoring division, one quotient bit per cycle.
            ST_DIV:
            begin
                rem_next = quo_bit ? DIV_W'(rem_shift - {1'b0, div_reg})
                                   : rem_shift[DIV_W-1:0];
                quo_next = {quo_reg[DIV_STEPS-2:0], quo_bit};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    prod_next  = {{PWR_W{1'b0}}, 1'b0, quo_reg[DIV_STEPS-2:0], quo_bit};
                    state_next = ST_SLOPE;
                end
            end

            // Shift-add product of the fraction and the power span.
            ST_SLOPE:
            begin
                prod_next = {slope_sum, prod_reg[FRAC_W-1:1]};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SLOPE_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_POWER;
                end
            end

            // Epsilon plus the floored slope, or minus its ceiling when falling.
            ST_POWER:
            begin
                power_next = power_calc[PWR_W-1:0];
                state_next = ST_ENERGY;
            end

            // Bit-serial product of power and elapsed ticks.
            ST_ENERGY:
            begin
                eprod_next = {energy_sum, eprod_reg[TIME_W-1:1]};
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TIME_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end
            end

            // Accumulate, latch the new state and post the result.
            ST_FINISH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    acc_next         = acc_new;
                    latched_off_next = !host_on_reg;
                    if (host_on_reg)
                    begin
                        latched_pstate_next = new_pstate_reg;
                    end
                    out_energy_next = acc_new;
                    out_power_next  = power_reg;
                    out_used_next   = used_reg;
                    out_sat_next    = acc_new == ACC_MAX;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            valid_reg          <= '0;
            m_valid_reg        <= 1'b0;
            latched_pstate_reg <= '0;
            latched_off_reg    <= 1'b0;
            last_time_reg      <= '0;
            acc_reg            <= '0;
            used_reg           <= 1'b0;
            off_power_reg      <= '0;
            core_count_reg     <= CORE_W'(1);
            cnt_reg            <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            valid_reg          <= valid_next;
            m_valid_reg        <= m_valid_next;
            latched_pstate_reg <= latched_pstate_next;
            latched_off_reg    <= latched_off_next;
            last_time_reg      <= last_time_next;
            acc_reg            <= acc_next;
            used_reg           <= used_next;
            off_power_reg      <= off_power_next;
            core_count_reg     <= core_count_next;
            cnt_reg            <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        later_reg      <= later_next;
        host_on_reg    <= host_on_next;
        new_pstate_reg <= new_pstate_next;
        load_reg       <= load_next;
        div_reg        <= div_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        eps_reg        <= eps_next;
        diff_reg       <= diff_next;
        neg_reg        <= neg_next;
        prod_reg       <= prod_next;
        power_reg      <= power_next;
        eprod_reg      <= eprod_next;
        out_energy_reg <= out_energy_next;
        out_power_reg  <= out_power_next;
        out_used_reg   <= out_used_next;
        out_sat_reg    <= out_sat_next;
    end

    // Result port.
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0, out_sat_reg, out_used_reg, out_power_reg, out_energy_reg};

endmodule

@@ tb/tb_load_based_energy_meter.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the load-based energy meter: directed and random event traffic.
module tb_load_based_energy_meter;
    import lbem_pkg::*;

    localparam int SETTLE_CYCLES  = 150;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 4;
    localparam int PHASE_ITEMS    = 350;
    localparam int MAX_PRINTED    = 40;
    localparam logic [63:0] ENERGY_CEIL = {1'b0, ACC_MAX};

    // One input transaction, field by field.
    typedef struct packed {
        logic        cmd;
        logic [47:0] now_time;
        logic        host_on;
        logic [2:0]  new_pstate;
        logic [31:0] load_rate;
        logic [2:0]  table_index;
        logic [31:0] idle_pwr;
        logic [31:0] eps_pwr;
        logic [31:0] max_pwr;
        logic [31:0] pstate_speed;
    } meter_item_t;

    // One meter reading as the block should report it.
    typedef struct packed {
        logic [62:0] energy;
        logic [31:0] power;
        logic        used;
        logic        saturated;
    } meter_reading_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [215:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_addr;
    logic [31:0]  cfg_data;

    // Shadow copy of the meter state, updated as transactions are accepted.
    logic [31:0]    shadow_idle [8];
    logic [31:0]    shadow_eps [8];
    logic [31:0]    shadow_max [8];
    logic [31:0]    shadow_speed [8];
    logic [2:0]     shadow_pstate;
    logic           shadow_off;
    logic [47:0]    shadow_last_tick;
    logic [63:0]    shadow_energy;
    logic           shadow_used;
    logic [31:0]    shadow_off_power;
    logic [8:0]     shadow_cores;
    meter_reading_t pending_readings[$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int gap_limit      = 0;
    int burst_left     = 0;
    int stall_mode     = 0;
    int stall_run      = 0;

    load_based_energy_meter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Power charged for the latched state over one interval.
    // The loaded flag tells whether this interval counts as used.
    function automatic logic [31:0] charged_power(input logic [31:0] load, output logic loaded);
        logic [31:0] idle_w;
        logic [31:0] eps_w;
        logic [31:0] max_w;
        logic [31:0] spd;
        logic [8:0]  cores;
        logic [63:0] frac;
        logic [63:0] prod;
        loaded = 1'b0;
        if (shadow_off)
            return shadow_off_power;
        idle_w = shadow_idle[shadow_pstate];
        eps_w  = shadow_eps[shadow_pstate];
        max_w  = shadow_max[shadow_pstate];
        spd    = shadow_speed[shadow_pstate];
        if (spd == 0)
        begin
            // A zero speed counts as fully loaded and leaves the used flag alone.
            frac = 64'(FRAC_ONE);
        end
        else
        begin
            cores = (shadow_cores == 0) ? 9'd1 : shadow_cores;
            frac  = {16'h0, load, 16'h0} / (64'(spd) * 64'(cores));
            if (frac > 64'(FRAC_ONE))
                frac = 64'(FRAC_ONE);
            loaded = (load != 0);
            if (load == 0)
                return idle_w;
        end
        if (max_w >= eps_w)
        begin
            prod = frac * 64'(max_w - eps_w);
            return eps_w + 32'(prod >> 16);
        end
        // Falling slope: the product is rounded up, so the power is floored toward minus infinity.
        prod = frac * 64'(eps_w - max_w);
        return eps_w - 32'((prod + 64'hFFFF) >> 16);
    endfunction

    // Apply one accepted transaction to the shadow state and queue its reading.
    task automatic account_item(input meter_item_t it);
        logic [63:0]    dt;
        logic [63:0]    pw;
        logic           loaded;
        meter_reading_t reading;
        if (it.cmd == CMD_TABLE_WR)
        begin
            shadow_idle[it.table_index]  = it.idle_pwr;
            shadow_eps[it.table_index]   = it.eps_pwr;
            shadow_max[it.table_index]   = it.max_pwr;
            shadow_speed[it.table_index] = it.pstate_speed;
            return;
        end
        pw = 64'd0;
        if (it.now_time > shadow_last_tick)
        begin
            dt = 64'(it.now_time - shadow_last_tick);
            pw = 64'(charged_power(it.load_rate, loaded));
            if (loaded)
                shadow_used = 1'b1;
            if (pw != 0 && dt > (ENERGY_CEIL - shadow_energy) / pw)
                shadow_energy = ENERGY_CEIL;
            else
                shadow_energy = shadow_energy + pw * dt;
            shadow_last_tick = it.now_time;
        end
        // Latch the state for the next interval; off keeps the old pstate.
        if (it.host_on)
        begin
            shadow_off    = 1'b0;
            shadow_pstate = it.new_pstate;
        end
        else
        begin
            shadow_off = 1'b1;
        end
        reading.energy    = shadow_energy[62:0];
        reading.power     = pw[31:0];
        reading.used      = shadow_used;
        reading.saturated = (shadow_energy == ENERGY_CEIL);
        pending_readings.insert(pending_readings.size(), reading);
    endtask

    // Random word whose magnitude is spread over all bit lengths.
    function automatic logic [31:0] scaled_random();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // Transaction with every field random, as a base for the builders below.
    function automatic meter_item_t noise_item();
        meter_item_t it;
        it.cmd          = CMD_UPDATE;
        it.now_time     = 48'({$urandom, $urandom});
        it.host_on      = 1'($urandom);
        it.new_pstate   = 3'($urandom);
        it.load_rate    = $urandom;
        it.table_index  = 3'($urandom);
        it.idle_pwr     = $urandom;
        it.eps_pwr      = $urandom;
        it.max_pwr      = $urandom;
        it.pstate_speed = $urandom;
        return it;
    endfunction

    function automatic meter_item_t table_item(input logic [2:0] idx, input logic [31:0] idle_w,
                                               input logic [31:0] eps_w, input logic [31:0] max_w,
                                               input logic [31:0] spd);
        meter_item_t it;
        it              = noise_item();
        it.cmd          = CMD_TABLE_WR;
        it.table_index  = idx;
        it.idle_pwr     = idle_w;
        it.eps_pwr      = eps_w;
        it.max_pwr      = max_w;
        it.pstate_speed = spd;
        return it;
    endfunction

    function automatic meter_item_t update_item(input logic [47:0] now, input logic on,
                                                input logic [2:0] ps, input logic [31:0] load);
        meter_item_t it;
        it            = noise_item();
        it.cmd        = CMD_UPDATE;
        it.now_time   = now;
        it.host_on    = on;
        it.new_pstate = ps;
        it.load_rate  = load;
        return it;
    endfunction

    // Send one transaction in bursts with random gaps; starts and ends at a falling edge.
    task automatic send_item(input meter_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
            if (gap != 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tdata  = {1'b0, it.pstate_speed, it.max_pwr, it.eps_pwr, it.idle_pwr,
                         it.table_index, it.load_rate, it.new_pstate, it.host_on, it.now_time};
        s_axis_tuser  = it.cmd;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        account_item(it);
        @(negedge clk);
    endtask

    // Write one configuration register; only called while the block is idle.
    task automatic write_register(input logic addr, input logic [31:0] value);
        cfg_addr  = addr;
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (addr == CFG_OFF_POWER)
            shadow_off_power = value;
        else
            shadow_cores = value[8:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Wait until every reading has arrived and the datapath has gone quiet.
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    endtask

    // Empty table after reset: every entry has zero speed and zero power.
    task automatic test_reset_state();
        send_item(update_item(48'd0, 1'b1, 3'd3, 32'd5));
        send_item(update_item(48'd100, 1'b1, 3'd4, 32'hFFFF_FFFF));
        send_item(update_item(48'd250, 1'b0, 3'd6, 32'd0));
    endtask

    // Table entries at the extremes, every load shape and several core counts.
    task automatic test_pstate_table();
        settle();
        write_register(CFG_CORE_COUNT, 32'd0);
        write_register(CFG_OFF_POWER, 32'h0001_8000);
        send_item(table_item(3'd1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(table_item(3'd2, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0, 32'h0000_1000));
        send_item(table_item(3'd3, 32'h0000_2000, 32'h0000_5000, 32'h0000_9000, 32'h0));
        send_item(table_item(3'd7, 32'h0, 32'h0000_4000, 32'h0004_0000, 32'h0000_0300));
        send_item(update_item(48'd300, 1'b1, 3'd1, $urandom));
        // Zero load gives idle power, a load that truncates to zero gives epsilon.
        send_item(update_item(48'd400, 1'b1, 3'd1, 32'd0));
        send_item(update_item(48'd500, 1'b1, 3'd1, 32'd1));
        send_item(update_item(48'd600, 1'b1, 3'd2, 32'hFFFF_FFFF));
        // Epsilon above max: a falling slope.
        send_item(update_item(48'd700, 1'b1, 3'd2, 32'h0000_0800));
        send_item(update_item(48'd800, 1'b1, 3'd3, 32'd0));
        // Zero speed reads as full load even with no work.
        send_item(update_item(48'd900, 1'b1, 3'd7, 32'd0));
        send_item(update_item(48'd1000, 1'b1, 3'd7, 32'h0000_0180));
        settle();
        write_register(CFG_CORE_COUNT, 32'd256);
        send_item(update_item(48'd1100, 1'b1, 3'd7, 32'h0000_0300 * 256));
        settle();
        // Only the low nine bits hold the core count.
        write_register(CFG_CORE_COUNT, 32'hABCD_E1FF);
        send_item(update_item(48'd1200, 1'b1, 3'd7, 32'h0000_0300));
    endtask

    // Host off charges the off power at both extremes.
    task automatic test_host_off();
        settle();
        write_register(CFG_OFF_POWER, 32'hFFFF_FFFF);
        send_item(update_item(48'd1300, 1'b0, 3'd5, $urandom));
        send_item(update_item(48'd1400, 1'b0, 3'd6, $urandom));
        settle();
        write_register(CFG_OFF_POWER, 32'd0);
        send_item(update_item(48'd1500, 1'b1, 3'd1, $urandom));
        send_item(update_item(48'd1600, 1'b1, 3'd2, scaled_random()));
    endtask

    // Times that are not later than the last update charge nothing but still latch.
    task automatic test_stale_time();
        send_item(update_item(48'd1600, 1'b1, 3'd2, $urandom));
        send_item(update_item(48'd1000, 1'b0, 3'd3, $urandom));
        send_item(update_item(48'd1601, 1'b1, 3'd1, scaled_random()));
    endtask

    // Random table writes and update events over several settings and idling patterns.
    task automatic test_random_traffic();
        meter_item_t it;
        int unsigned pick;
        logic [47:0] now;
        logic [31:0] load;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    write_register(CFG_OFF_POWER, $urandom);
                    write_register(CFG_CORE_COUNT, 32'd1);
                end
                1:
                begin
                    write_register(CFG_OFF_POWER, 32'hFFFF_FFFF);
                    write_register(CFG_CORE_COUNT, 32'd256);
                end
                2:
                begin
                    write_register(CFG_OFF_POWER, 32'd0);
                    write_register(CFG_CORE_COUNT, 32'd0);
                end
                default:
                begin
                    write_register(CFG_OFF_POWER, scaled_random());
                    write_register(CFG_CORE_COUNT, $urandom);
                end
            endcase
            gap_limit  = (phase == 0) ? 0 : (phase == 1) ? 3 : 12;
            stall_mode = (phase == 0) ? 0 : (phase == 1) ? 1 : 2;
            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                begin
                    it = table_item(3'($urandom), scaled_random(), scaled_random(),
                                    scaled_random(),
                                    ($urandom_range(0, 6) == 0) ? 32'd0 : scaled_random());
                end
                else
                begin
                    // Mostly small steps forward, some repeats, some going back, a few long jumps.
                    pick = $urandom_range(0, 99);
                    if (pick < 7)
                        now = shadow_last_tick;
                    else if (pick < 11)
                        now = (shadow_last_tick > 48'd4096) ?
                              shadow_last_tick - 48'($urandom_range(1, 4096)) : 48'd0;
                    else if (pick < 14)
                        now = shadow_last_tick + 48'($urandom_range(1, 1 << 20));
                    else
                        now = shadow_last_tick + 48'($urandom_range(1, 5000));
                    pick = $urandom_range(0, 99);
                    load = (pick < 12) ? 32'd0 : (pick < 30) ? $urandom : scaled_random();
                    it = update_item(now, $urandom_range(0, 9) != 0, 3'($urandom), load);
                end
                send_item(it);
            end
        end
        gap_limit  = 0;
        stall_mode = 0;
    endtask

    // Long intervals up to the top of the time range, then accumulator saturation.
    task automatic test_saturation();
        settle();
        write_register(CFG_OFF_POWER, 32'd1);
        send_item(update_item(shadow_last_tick + 48'd1, 1'b0, 3'd0, $urandom));
        send_item(update_item(shadow_last_tick + 48'h8000_0000_0000, 1'b0, 3'd4, $urandom));
        settle();
        write_register(CFG_OFF_POWER, 32'hFFFF_FFFF);
        send_item(update_item(48'hFFFF_FFFF_FFFE, 1'b1, 3'd1, $urandom));
        send_item(update_item(48'hFFFF_FFFF_FFFF, 1'b0, 3'd0, 32'hFFFF_FFFF));
        send_item(update_item(48'h0, 1'b1, 3'd2, $urandom));
    endtask

    // Receiver stall pattern, chosen per phase.
    always @(negedge clk)
    begin
        if (stall_mode == 0)
            m_axis_tready <= 1'b1;
        else if (stall_run > 0)
            stall_run <= stall_run - 1;
        else
        begin
            m_axis_tready <= ($urandom_range(0, 2) != 0);
            stall_run     <= $urandom_range(0, (stall_mode == 1) ? 2 : 40);
        end
    end

    // Compare each result transaction with the oldest expected reading.
    always @(posedge clk)
    begin : result_check
        meter_reading_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_readings.size() == 0)
            begin
                report_mismatch("unexpected result", 64'd0, 64'(m_axis_tdata[62:0]));
            end
            else
            begin
                want = pending_readings.pop_front();
                if (m_axis_tdata[62:0] !== want.energy)
                    report_mismatch("energy_total", 64'(want.energy),
                                    64'(m_axis_tdata[62:0]));
                if (m_axis_tdata[94:63] !== want.power)
                    report_mismatch("interval_power", 64'(want.power),
                                    64'(m_axis_tdata[94:63]));
                if (m_axis_tdata[95] !== want.used)
                    report_mismatch("host_used", 64'(want.used), 64'(m_axis_tdata[95]));
                if (m_axis_tdata[96] !== want.saturated)
                    report_mismatch("energy_saturated", 64'(want.saturated),
                                    64'(m_axis_tdata[96]));
            end
        end
    end

    // Watchdog: end the run after too long without any transaction.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_UPDATE;
        cfg_valid     = 1'b0;
        cfg_addr      = CFG_OFF_POWER;
        cfg_data      = '0;
        for (int i = 0; i < 8; i++)
        begin
            shadow_idle[i]  = '0;
            shadow_eps[i]   = '0;
            shadow_max[i]   = '0;
            shadow_speed[i] = '0;
        end
        shadow_pstate    = '0;
        shadow_off       = 1'b0;
        shadow_last_tick = '0;
        shadow_energy    = '0;
        shadow_used      = 1'b0;
        shadow_off_power = '0;
        shadow_cores     = 9'd1;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_pstate_table();
        test_host_off();
        test_stale_time();
        test_random_traffic();
        test_saturation();
        settle();

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/lbem_pkg.sv
design/lbem_ram.sv
design/load_based_energy_meter.sv
tb/tb_load_based_energy_meter.sv
